### src/tconv_pkg.sv
package tconv_pkg;

  // Item function codes, carried in tuser
  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_ACT    = 2'd2;

  // Configuration register indexes
  localparam logic REG_IN_COUNT  = 1'b0;
  localparam logic REG_OUT_COUNT = 1'b1;

  localparam logic [15:0] WEIGHT_ONE = 16'h0100;  // 1.0 in Q8.8

  localparam logic signed [39:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] SUM_MIN = 40'sh80_0000_0000;

  // Request as it walks down the cell chain
  typedef struct packed {
    logic               valid;
    logic [1:0]         func;
    logic [3:0]         in_chan;
    logic [3:0]         out_chan;
    logic [1:0]         tap;
    logic signed [15:0] value;
    logic               emit;
    logic [4:0]         nout;
  } tok_t;

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    logic signed [39:0] r;
    if (v[40] != v[39]) begin
      r = v[40] ? SUM_MIN : SUM_MAX;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

### src/tconv_ram.sv
module tconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tconv_cell.sv
module tconv_cell #(
  parameter int IDX  = 0,
  parameter int ROWS = 16,
  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clr,
  input  logic [AW-1:0]          clr_row,
  input  tconv_pkg::tok_t        tok_in,
  output tconv_pkg::tok_t        tok_out,
  input  logic                   shift,
  input  logic signed [39:0]     ob_in,
  output logic signed [39:0]     ob_head,
  output logic                   done
);

  import tconv_pkg::*;

  tok_t               tok_q;
  logic [15:0]        bias;
  logic [15:0]        p_bias;
  logic [15:0]        wdat [4];
  logic signed [31:0] prod [4];
  logic signed [39:0] acc [4];
  logic signed [39:0] acc_next [4];
  logic signed [39:0] ob [4];
  logic               p_valid;
  logic               p_first;
  logic               p_emit;
  logic               act_q;
  logic [AW-1:0]      addr;
  logic signed [39:0] bias_wide;

  assign addr = clr ? clr_row : tok_in.in_chan[AW-1:0];
  assign act_q = tok_q.valid && (tok_q.func == FUNC_ACT) && (tok_q.nout > 5'(IDX));
  assign bias_wide = {{16{p_bias[15]}}, p_bias, 8'h00};

  for (genvar t = 0; t < 4; t++) begin : g_tap
    logic w_hit;
    logic signed [39:0] base;

    assign w_hit = tok_in.valid && (tok_in.func == FUNC_WEIGHT)
                   && (tok_in.out_chan == 4'(IDX)) && (tok_in.tap == 2'(t));
    assign base = p_first ? bias_wide : acc[t];
    assign acc_next[t] = sat40(41'(base) + 41'(prod[t]));

    tconv_ram #(.WIDTH(16), .DEPTH(ROWS)) u_wram (
      .clk   (clk),
      .we    (clr || w_hit),
      .waddr (addr),
      .wdata (clr ? WEIGHT_ONE : tok_in.value),
      .raddr (addr),
      .rdata (wdat[t])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q.valid <= 1'b0;
      bias        <= '0;
      p_valid     <= 1'b0;
      p_emit      <= 1'b0;
    end else begin
      tok_q <= tok_in;
      if (tok_in.valid && (tok_in.func == FUNC_BIAS) && (tok_in.out_chan == 4'(IDX))) begin
        bias <= tok_in.value;
      end
      p_valid <= act_q;
      // done must fire even when this channel is out of use
      p_emit  <= tok_q.valid && (tok_q.func == FUNC_ACT) && tok_q.emit;
    end
  end

  always_ff @(posedge clk) begin
    p_first <= (tok_q.in_chan == 4'd0);
    // hold the bias seen by the request in tok_q, ahead of any later load
    p_bias  <= bias;
    for (int t = 0; t < 4; t++) begin
      prod[t] <= 32'(tok_q.value) * 32'($signed(wdat[t]));
      if (p_valid) begin
        acc[t] <= acc_next[t];
      end
    end
    // snapshot on the final channel, otherwise advance the result chain
    if (p_valid && p_emit) begin
      for (int t = 0; t < 4; t++) begin
        ob[t] <= acc_next[t];
      end
    end else if (shift) begin
      ob[0] <= ob[1];
      ob[1] <= ob[2];
      ob[2] <= ob[3];
      ob[3] <= ob_in;
    end
  end

  assign tok_out = tok_q;
  assign ob_head = ob[0];
  assign done    = p_emit;

endmodule

### src/transposed_conv_2x2_stride2.sv
// Channel   | Dir | Handshake              | Payload
// s_        | in  | s_tvalid / s_tready    | s_tuser: func; s_tdata: request fields
// m_        | out | m_tvalid / m_tready    | m_tdata: result fields; m_tlast: last
// cfg_      | in  | cfg_we                 | cfg_index, cfg_data
// Weight/bias loads and non-final activations are accepted one per cycle unless
// s_tready is held low. A final-channel activation holds s_tready low while it
// walks the cell chain and while its results, four per output channel in use,
// drain one per cycle from the cell shift chain (longer if m_tready stalls).
// After reset a clearing pass writes 1.0 into all min(IN_CH,16) rows of the
// weight RAMs; s_tready stays low during it. Config writes are taken always.
module transposed_conv_2x2_stride2 #(
  parameter int IN_CH  = 16,
  parameter int OUT_CH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // func
  input  logic [47:0] s_tdata,   // in_chan, out_chan, tap, value, in_row, in_col, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // res_chan, out_row, out_col, sum, zero pad
  output logic        m_tlast,   // last
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  import tconv_pkg::*;

  localparam int W_ROWS = (IN_CH < 16) ? IN_CH : 16;
  localparam int WA = (W_ROWS > 1) ? $clog2(W_ROWS) : 1;
  localparam int CW = $clog2(OUT_CH * 4);

  logic [3:0]         in_chan;
  logic [3:0]         out_chan;
  logic [1:0]         tap;
  logic signed [15:0] value;
  logic [9:0]         in_row;
  logic [9:0]         in_col;

  logic               clearing;
  logic [WA-1:0]      clr_row;
  logic [4:0]         in_count;
  logic [4:0]         out_count;
  logic [4:0]         nin;
  logic [4:0]         nout;
  tok_t               tok0;
  tok_t               tok_next;
  logic               accept;
  logic               act_ok;
  logic               emits;
  logic               emit_busy;
  logic               drain;
  logic               step;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      last_idx;
  logic [9:0]         row_q;
  logic [9:0]         col_q;
  logic [3:0]         o_chan;
  logic [10:0]        o_row;
  logic [10:0]        o_col;
  logic signed [39:0] o_sum;
  logic               o_last;

  tok_t               tok_w [OUT_CH];
  tok_t               tok_o [OUT_CH];
  logic signed [39:0] head_w [OUT_CH];
  logic signed [39:0] obin_w [OUT_CH];
  logic               done_w [OUT_CH];

  assign in_chan  = s_tdata[3:0];
  assign out_chan = s_tdata[7:4];
  assign tap      = s_tdata[9:8];
  assign value    = s_tdata[25:10];
  assign in_row   = s_tdata[35:26];
  assign in_col   = s_tdata[45:36];

  assign nin  = (in_count == 5'd0) ? 5'd1 :
                (in_count > 5'(W_ROWS)) ? 5'(W_ROWS) : in_count;
  assign nout = (out_count == 5'd0) ? 5'd1 :
                (out_count > 5'(OUT_CH)) ? 5'(OUT_CH) : out_count;

  assign s_tready = !clearing && !emit_busy;
  assign accept   = s_tvalid && s_tready;
  assign act_ok   = (s_tuser == FUNC_ACT) && ({1'b0, in_chan} < nin);
  assign emits    = act_ok && ({1'b0, in_chan} == (nin - 5'd1));
  assign step     = drain && (!m_tvalid || m_tready);

  always_comb begin
    tok_next.valid    = accept && (((s_tuser == FUNC_WEIGHT) && (int'(in_chan) < IN_CH))
                                   || (s_tuser == FUNC_BIAS) || act_ok);
    tok_next.func     = s_tuser;
    tok_next.in_chan  = in_chan;
    tok_next.out_chan = out_chan;
    tok_next.tap      = tap;
    tok_next.value    = value;
    tok_next.emit     = emits;
    tok_next.nout     = nout;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_row    <= '0;
      in_count   <= 5'd1;
      out_count  <= 5'd1;
      tok0.valid <= 1'b0;
      emit_busy  <= 1'b0;
      drain      <= 1'b0;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
        if (clr_row == WA'(W_ROWS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IN_COUNT:  in_count  <= cfg_data;
          REG_OUT_COUNT: out_count <= cfg_data;
          default: ;
        endcase
      end
      tok0 <= tok_next;
      if (accept && emits) begin
        emit_busy <= 1'b1;
      end
      // last cell raises done (and loads its snapshot if in use): start draining
      if (done_w[OUT_CH-1]) begin
        drain <= 1'b1;
        cnt   <= '0;
      end
      if (step) begin
        m_tvalid <= 1'b1;
        cnt      <= cnt + 1'b1;
        if (cnt == last_idx) begin
          drain     <= 1'b0;
          emit_busy <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emits) begin
      row_q    <= in_row;
      col_q    <= in_col;
      last_idx <= CW'({2'b00, nout, 2'b00} - 9'd1);
    end
    if (step) begin
      o_chan <= 4'(cnt >> 2);
      o_row  <= {row_q, cnt[1]};
      o_col  <= {col_q, cnt[0]};
      o_sum  <= head_w[0];
      o_last <= (cnt == last_idx);
    end
  end

  assign m_tdata = {6'd0, o_sum, o_col, o_row, o_chan};
  assign m_tlast = o_last;

  assign tok_w[0] = tok0;

  for (genvar c = 0; c < OUT_CH; c++) begin : g_cell
    if (c == OUT_CH - 1) begin : g_end
      assign obin_w[c] = '0;
    end else begin : g_mid
      assign obin_w[c]  = head_w[c+1];
      assign tok_w[c+1] = tok_o[c];
    end

    tconv_cell #(.IDX(c), .ROWS(W_ROWS)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clr     (clearing),
      .clr_row (clr_row),
      .tok_in  (tok_w[c]),
      .tok_out (tok_o[c]),
      .shift   (step),
      .ob_in   (obin_w[c]),
      .ob_head (head_w[c]),
      .done    (done_w[c])
    );
  end

  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    drain |-> emit_busy)
    else $error("drain running without a final-channel request in flight");

  a_snap_idle: assert property (@(posedge clk) disable iff (rst)
    done_w[OUT_CH-1] |-> (emit_busy && !drain))
    else $error("snapshot landed while results were draining");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (step && (cnt == last_idx)) |=> !drain)
    else $error("drain still active after the last result");

  a_no_out_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!m_tvalid && !emit_busy))
    else $error("activity during weight clearing pass");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    drain |-> (cnt <= last_idx))
    else $error("drain counter ran past the last result");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tconv_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;   // undefined function, dropped by the block
  localparam int CHANS = 16;
  localparam int SETTLE = 32;                // covers the walk of a request down the cell chain
  localparam logic signed [40:0] ACC_TOP = 41'sd549755813887;
  localparam logic signed [40:0] ACC_BOTTOM = -41'sd549755813888;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         in_chan;
    logic [3:0]         out_chan;
    logic [1:0]         tap;
    logic signed [15:0] value;
    logic [9:0]         in_row;
    logic [9:0]         in_col;
  } req_t;

  typedef struct packed {
    logic [3:0]         chan;
    logic [10:0]        out_row;
    logic [10:0]        out_col;
    logic signed [39:0] acc_sum;
    logic               last;
  } res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  transposed_conv_2x2_stride2 uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: weights, biases, accumulators, count registers
  logic signed [15:0] kernel[CHANS][CHANS][4];
  logic signed [15:0] bias_vals[CHANS];
  logic signed [39:0] acc_regs[CHANS*4];
  logic [4:0]         in_raw = 5'd1;
  logic [4:0]         out_raw = 5'd1;

  req_t req_queue[$];
  res_t conv_results_due[$];

  // Stimulus-side view of which output channels hold a started pixel
  logic     acc_started[CHANS];
  int       gen_nin = 1;
  int       gen_nout = 1;

  int       mismatches = 0;
  int       results_checked = 0;
  int       requests_sent = 0;
  int       reqs_planned = 0;
  int       sat_hits = 0;
  int       tx_gap = 0;
  int       rx_hold = 0;
  logic     tx_steady = 1'b0;
  logic     rx_steady = 1'b0;
  logic     in_fire = 1'b0;
  req_t     tx_req;
  req_t     seen_req;
  res_t     got_res;

  function automatic int clamp_count(logic [4:0] raw);
    int n;
    n = int'(raw);
    if (n < 1) n = 1;
    if (n > CHANS) n = CHANS;
    return n;
  endfunction

  function automatic void conv_predict(req_t r);
    int nin, nout, c, t;
    logic signed [40:0] base, total;
    logic signed [31:0] prod;
    logic [1:0] tp;
    res_t e;
    case (r.func)
      FUNC_WEIGHT: kernel[r.in_chan][r.out_chan][r.tap] = r.value;
      FUNC_BIAS: bias_vals[r.out_chan] = r.value;
      FUNC_ACT: begin
        nin = clamp_count(in_raw);
        nout = clamp_count(out_raw);
        if (int'(r.in_chan) < nin) begin
          for (c = 0; c < nout; c++) begin
            for (t = 0; t < 4; t++) begin
              prod = 32'(r.value) * 32'(kernel[r.in_chan][c][t]);
              if (r.in_chan == 0) begin
                base = 41'(bias_vals[c]);
                base = base * 41'sd256;
              end else begin
                base = 41'(acc_regs[c*4+t]);
              end
              total = base + 41'(prod);
              if (total > ACC_TOP) acc_regs[c*4+t] = ACC_TOP[39:0];
              else if (total < ACC_BOTTOM) acc_regs[c*4+t] = ACC_BOTTOM[39:0];
              else acc_regs[c*4+t] = total[39:0];
            end
          end
          if (int'(r.in_chan) == nin - 1) begin
            for (c = 0; c < nout; c++) begin
              for (t = 0; t < 4; t++) begin
                tp = t[1:0];
                e.chan = c[3:0];
                e.out_row = {r.in_row, tp[1]};
                e.out_col = {r.in_col, tp[0]};
                e.acc_sum = acc_regs[c*4+t];
                e.last = (c == nout - 1) && (t == 3);
                conv_results_due.push_back(e);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap(logic steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sender: present the next request at the falling edge, hold until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_fire) begin
    end else if (tx_gap != 0) begin
      s_tvalid <= 1'b0;
      tx_gap <= tx_gap - 1;
    end else if (req_queue.size() != 0) begin
      tx_req = req_queue.pop_front();
      s_tvalid <= 1'b1;
      s_tuser <= tx_req.func;
      s_tdata <= {2'b00, tx_req.in_col, tx_req.in_row, tx_req.value, tx_req.tap,
                  tx_req.out_chan, tx_req.in_chan};
      tx_gap <= pick_gap(tx_steady);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: random back-pressure on results
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 20) rx_hold <= pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    in_fire <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen_req.func = s_tuser;
        seen_req.in_chan = s_tdata[3:0];
        seen_req.out_chan = s_tdata[7:4];
        seen_req.tap = s_tdata[9:8];
        seen_req.value = s_tdata[25:10];
        seen_req.in_row = s_tdata[35:26];
        seen_req.in_col = s_tdata[45:36];
        conv_predict(seen_req);
        requests_sent++;
      end
      if (m_tvalid && m_tready) begin
        got_res.chan = m_tdata[3:0];
        got_res.out_row = m_tdata[14:4];
        got_res.out_col = m_tdata[25:15];
        got_res.acc_sum = m_tdata[65:26];
        got_res.last = m_tlast;
        results_checked++;
        if (got_res.acc_sum == ACC_TOP[39:0] || got_res.acc_sum == ACC_BOTTOM[39:0])
          sat_hits++;
        if (conv_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result chan %0d row %0d col %0d sum %0d last %0b",
                     $realtime, got_res.chan, got_res.out_row, got_res.out_col,
                     got_res.acc_sum, got_res.last);
        end else if (got_res != conv_results_due[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch got chan %0d row %0d col %0d sum %0d last %0b",
                     $realtime, got_res.chan, got_res.out_row, got_res.out_col,
                     got_res.acc_sum, got_res.last);
            $display("    expected chan %0d row %0d col %0d sum %0d last %0b",
                     conv_results_due[0].chan, conv_results_due[0].out_row,
                     conv_results_due[0].out_col, conv_results_due[0].acc_sum,
                     conv_results_due[0].last);
          end
          void'(conv_results_due.pop_front());
        end else begin
          void'(conv_results_due.pop_front());
        end
      end
    end
  end

  task automatic cfg_write(logic [0:0] idx, logic [4:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_IN_COUNT) in_raw = data;
    else out_raw = data;
    gen_nin = clamp_count(in_raw);
    gen_nout = clamp_count(out_raw);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_counts(logic [4:0] nin_raw, logic [4:0] nout_raw);
    cfg_write(REG_IN_COUNT, nin_raw);
    cfg_write(REG_OUT_COUNT, nout_raw);
  endtask

  task automatic push_req(logic [1:0] f, logic [3:0] ic, logic [3:0] oc, logic [1:0] tap,
                          logic [15:0] v, logic [9:0] row, logic [9:0] col);
    req_t r;
    r = '{func: f, in_chan: ic, out_chan: oc, tap: tap, value: v, in_row: row,
          in_col: col};
    req_queue.push_back(r);
    if (!(f == FUNC_NONE || (f == FUNC_ACT && int'(ic) >= gen_nin))) reqs_planned++;
    if (f == FUNC_ACT && ic == 0)
      for (int c = 0; c < gen_nout; c++) acc_started[c] = 1'b1;
  endtask

  // Channels 0..upto of one pixel; upto below nin-1 leaves the pixel unfinished
  task automatic push_pixel(int upto);
    logic [9:0] row, col;
    row = 10'($urandom);
    col = 10'($urandom);
    for (int ch = 0; ch <= upto; ch++)
      push_req(FUNC_ACT, ch[3:0], 4'($urandom), 2'($urandom), pick_value(), row, col);
  endtask

  function automatic logic stale_ok();
    for (int c = 0; c < gen_nout; c++)
      if (!acc_started[c]) return 1'b0;
    return 1'b1;
  endfunction

  // Let every queued request and every due result drain, then let the pipe settle
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (req_queue.size() != 0 || s_tvalid || conv_results_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 5'd0;
    if (r < 12) return 5'($urandom_range(17, 31));
    if (r < 40) return 5'($urandom_range(1, 3));
    return 5'($urandom_range(1, 16));
  endfunction

  initial begin
    int sel, target, upto;
    for (int i = 0; i < CHANS; i++) begin
      bias_vals[i] = '0;
      acc_started[i] = 1'b0;
      for (int j = 0; j < CHANS; j++)
        for (int t = 0; t < 4; t++) kernel[i][j][t] = WEIGHT_ONE;
    end
    for (int i = 0; i < CHANS*4; i++) acc_regs[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one channel in, one channel out, straight after reset
    push_req(FUNC_ACT, 4'd0, 4'd0, 2'd0, 16'h7FFF, 10'd1023, 10'd1023);
    push_req(FUNC_ACT, 4'd0, 4'hF, 2'd3, 16'h8000, 10'd0, 10'd0);
    push_req(FUNC_NONE, 4'hF, 4'hF, 2'd3, 16'hFFFF, 10'h3FF, 10'h3FF);
    push_req(FUNC_ACT, 4'd1, 4'd0, 2'd0, 16'h1234, 10'd5, 10'd6);
    push_req(FUNC_WEIGHT, 4'd15, 4'd15, 2'd3, 16'h8000, 10'd0, 10'd0);
    push_req(FUNC_WEIGHT, 4'd0, 4'd0, 2'd0, 16'h7FFF, 10'd0, 10'd0);
    push_req(FUNC_WEIGHT, 4'd0, 4'd0, 2'd1, 16'h8000, 10'd0, 10'd0);
    push_req(FUNC_WEIGHT, 4'd0, 4'd0, 2'd2, 16'h0000, 10'd0, 10'd0);
    push_req(FUNC_WEIGHT, 4'd0, 4'd0, 2'd3, 16'hFFFF, 10'd0, 10'd0);
    push_req(FUNC_BIAS, 4'd0, 4'd0, 2'd0, 16'h7FFF, 10'd0, 10'd0);
    push_req(FUNC_BIAS, 4'd0, 4'd15, 2'd0, 16'h8000, 10'd0, 10'd0);
    push_req(FUNC_ACT, 4'd0, 4'd0, 2'd0, 16'h8000, 10'h2AA, 10'h155);
    push_req(FUNC_ACT, 4'd0, 4'd0, 2'd0, 16'h7FFF, 10'h155, 10'h2AA);
    wait_idle();

    // Out-of-range counts clamp: in 0 acts as 1, out 31 as 16
    set_counts(5'd0, 5'd31);
    push_req(FUNC_ACT, 4'd0, 4'd0, 2'd0, 16'h8000, 10'd1023, 10'd0);
    push_req(FUNC_ACT, 4'd0, 4'd0, 2'd0, 16'h7FFF, 10'd0, 10'd1023);
    wait_idle();

    // Long back-to-back run of large products on stale accumulators
    set_counts(5'd16, 5'd1);
    tx_steady = 1'b1;
    push_req(FUNC_WEIGHT, 4'd1, 4'd0, 2'd0, 16'h8000, 10'd0, 10'd0);
    push_req(FUNC_WEIGHT, 4'd1, 4'd0, 2'd1, 16'h8000, 10'd0, 10'd0);
    push_req(FUNC_WEIGHT, 4'd1, 4'd0, 2'd2, 16'h7FFF, 10'd0, 10'd0);
    push_req(FUNC_WEIGHT, 4'd1, 4'd0, 2'd3, 16'h7FFF, 10'd0, 10'd0);
    push_req(FUNC_WEIGHT, 4'd15, 4'd0, 2'd0, 16'h0100, 10'd0, 10'd0);
    push_req(FUNC_ACT, 4'd0, 4'd0, 2'd0, 16'h7FFF, 10'($urandom), 10'($urandom));
    for (int round = 0; round < 2; round++) begin
      for (int k = 0; k < 40; k++)
        push_req(FUNC_ACT, 4'd1, 4'($urandom), 2'($urandom), 16'h8000, 10'($urandom),
                 10'($urandom));
      push_req(FUNC_ACT, 4'd15, 4'($urandom), 2'($urandom), pick_value(), 10'($urandom),
               10'($urandom));
    end
    wait_idle();

    // Random phases: mostly complete pixels, with loads, noise and broken runs
    for (int phase = 0; phase < 6; phase++) begin
      set_counts(pick_count(), pick_count());
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      target = reqs_planned + 56;
      while (reqs_planned < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          push_req(FUNC_WEIGHT, 4'($urandom), 4'($urandom), 2'($urandom), pick_value(),
                   10'($urandom), 10'($urandom));
        end else if (sel < 18) begin
          push_req(FUNC_BIAS, 4'($urandom), 4'($urandom), 2'($urandom), pick_value(),
                   10'($urandom), 10'($urandom));
        end else if (sel < 21) begin
          push_req(FUNC_NONE, 4'($urandom), 4'($urandom), 2'($urandom), 16'($urandom),
                   10'($urandom), 10'($urandom));
        end else if (sel < 24 && gen_nin < CHANS) begin
          push_req(FUNC_ACT, 4'($urandom_range(gen_nin, CHANS - 1)), 4'($urandom),
                   2'($urandom), 16'($urandom), 10'($urandom), 10'($urandom));
        end else if (sel < 28 && gen_nin > 1 && stale_ok()) begin
          push_req(FUNC_ACT, 4'($urandom_range(1, gen_nin - 1)), 4'($urandom),
                   2'($urandom), pick_value(), 10'($urandom), 10'($urandom));
        end else begin
          upto = gen_nin - 1;
          if (upto > 0 && $urandom_range(0, 9) == 0) upto = $urandom_range(0, upto - 1);
          push_pixel(upto);
        end
      end
      wait_idle();
    end

    $display("Sent %0d requests over 9 count settings; checked %0d results, %0d saturated.",
             requests_sent, results_checked, sat_hits);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still due", conv_results_due.size());
    $display("testbench failed");
    $finish;
  end

endmodule

### transposed_conv_2x2_stride2.f
src/tconv_pkg.sv
src/tconv_ram.sv
src/tconv_cell.sv
src/transposed_conv_2x2_stride2.sv
sim/testbench.sv
